@@ src/sample_variance_engine_core_macros.svh @@
// Assertion macros for the sample variance engine.
// Defined empty when SYNTH is set; the bodies expect clk and rst_n in scope.
`ifndef SAMPLE_VARIANCE_ENGINE_CORE_MACROS_SVH
`define SAMPLE_VARIANCE_ENGINE_CORE_MACROS_SVH
`ifndef SYNTH
`define SVE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sve: same-cycle check failed");
`define SVE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sve: next-cycle check failed");
`else
`define SVE_ASSERT_IMPL(label, ante, cons)
`define SVE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/sve_pkg.sv @@
// Shared widths, status codes and divider request/response types
// for the sample variance engine. No dependencies.
package sve_pkg;

    localparam int MAX_SAMPLES = 65536;

    localparam int SMP_W     = 16;
    localparam int CNT_W     = 17;
    localparam int SUM_W     = 33;
    localparam int SSQ_W     = 47;
    localparam int MEAN_W    = 24;
    localparam int VAR_W     = 39;
    localparam int STATUS_W  = 2;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int FRAC_W    = 8;
    localparam int DVD_W     = PROD_W + FRAC_W;
    localparam int DVS_W     = 32;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);
    localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(2);

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd2;

    typedef struct packed {
        logic             go;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             rem_nz;
        logic [VAR_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ src/sve_mul.sv @@
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on sve_pkg for widths.
module sve_mul (
    input  logic                        clk,
    input  logic [sve_pkg::MUL_W-1:0]   op_a,
    input  logic [sve_pkg::MUL_W-1:0]   op_b,
    output logic [sve_pkg::PROD_W-1:0]  prod
);

    logic [sve_pkg::PROD_W-1:0] prod_reg;
    logic [sve_pkg::PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = {{sve_pkg::MUL_W{1'b0}}, op_a} * {{sve_pkg::MUL_W{1'b0}}, op_b};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ src/sve_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// mean and variance divisions. Depends on sve_pkg for widths and types.
module sve_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sve_pkg::div_req_t req,
    output sve_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [sve_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [sve_pkg::DVS_W-1:0]     rem_reg, rem_next;
    logic [sve_pkg::DVD_W-1:0]     dvd_reg, dvd_next;
    logic [sve_pkg::VAR_W-1:0]     quo_reg, quo_next;
    logic [sve_pkg::DVS_W-1:0]     dvs_reg, dvs_next;
    logic [sve_pkg::DVS_W:0]       rem_sh;
    logic [sve_pkg::DVS_W:0]       rem_diff;
    logic                          fits;

    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[sve_pkg::DVD_W-1]};
        rem_diff = rem_sh - {1'b0, dvs_reg};
        fits     = (rem_sh >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (req.go)
        begin
            busy_next = 1'b1;
            cnt_next  = sve_pkg::DIV_CNT_W'(sve_pkg::DVD_W);
            rem_next  = '0;
            dvd_next  = req.dividend;
            quo_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when the divisor fits
            rem_next = fits ? rem_diff[sve_pkg::DVS_W-1:0] : rem_sh[sve_pkg::DVS_W-1:0];
            quo_next = {quo_reg[sve_pkg::VAR_W-2:0], fits};
            dvd_next = {dvd_reg[sve_pkg::DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg - sve_pkg::DIV_CNT_W'(1);
            if (cnt_reg == sve_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.rem_nz   = |rem_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ src/sample_variance_engine_core.sv @@
// Top level of the sample variance engine: sequencer, accumulators, result register.
// Depends on sve_pkg, sve_mul, sve_div and sample_variance_engine_core_macros.svh.
//
// A sample request is taken when start is high and busy is low. Every sample
// occupies the block through ST_SQ and ST_SQADD (a square through the shared
// 32x32 multiplier, then its accumulation). A marked sample that ends a valid
// batch adds ST_CHK, four multiplier passes that build n*S2 - S1^2 and n*(n-1),
// then two runs of the shared 72-step bit-serial divider, each after its start
// state, once for the mean and once for the variance. A batch that ends in an
// error status adds only ST_CHK, which registers its result. The result shows
// on mean_q8, variance_q8 and status in the one cycle in which done is high;
// mean_q8 may change before the next done, so it is not held for the receiver,
// which must take it then. Accumulators clear after every result.
`include "sample_variance_engine_core_macros.svh"
module sample_variance_engine_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [sve_pkg::SMP_W-1:0]    sample,
    input  logic                                last_sample,
    output logic                                busy,
    output logic                                done,
    output logic signed [sve_pkg::MEAN_W-1:0]   mean_q8,
    output logic [sve_pkg::VAR_W-1:0]           variance_q8,
    output logic [sve_pkg::STATUS_W-1:0]        status
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQ     = 4'd1;
    localparam logic [3:0] ST_SQADD  = 4'd2;
    localparam logic [3:0] ST_CHK    = 4'd3;
    localparam logic [3:0] ST_P0     = 4'd4;
    localparam logic [3:0] ST_P1     = 4'd5;
    localparam logic [3:0] ST_P2     = 4'd6;
    localparam logic [3:0] ST_P3     = 4'd7;
    localparam logic [3:0] ST_P4     = 4'd8;
    localparam logic [3:0] ST_MSTART = 4'd9;
    localparam logic [3:0] ST_MWAIT  = 4'd10;
    localparam logic [3:0] ST_VSTART = 4'd11;
    localparam logic [3:0] ST_VWAIT  = 4'd12;

    logic [3:0]                     state_reg, state_next;
    logic [sve_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [sve_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [sve_pkg::SSQ_W-1:0]      ssq_reg, ssq_next;
    logic                           ovf_reg, ovf_next;
    logic                           last_reg, last_next;
    logic                           acc_en_reg, acc_en_next;
    logic [sve_pkg::MUL_W-1:0]      op_a_reg, op_a_next;
    logic [sve_pkg::MUL_W-1:0]      op_b_reg, op_b_next;
    logic [sve_pkg::PROD_W-1:0]     acc_reg, acc_next;
    logic [sve_pkg::DVS_W-1:0]      den_reg, den_next;
    logic                           done_reg, done_next;
    logic [sve_pkg::MEAN_W-1:0]     mean_reg, mean_next;
    logic [sve_pkg::VAR_W-1:0]      var_reg, var_next;
    logic [sve_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic [sve_pkg::PROD_W-1:0]     prod;
    logic [sve_pkg::SMP_W-1:0]      smp_mag;
    logic [sve_pkg::SUM_W-1:0]      sum_abs;
    logic [sve_pkg::MUL_W-1:0]      sum_mag;
    logic                           sum_neg;
    logic [sve_pkg::MEAN_W-1:0]     mean_up;
    sve_pkg::div_req_t              div_req;
    sve_pkg::div_rsp_t              div_rsp;

    sve_mul u_mul (
        .clk  (clk),
        .op_a (op_a_reg),
        .op_b (op_b_reg),
        .prod (prod)
    );

    sve_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        smp_mag = sample[sve_pkg::SMP_W-1] ? sve_pkg::SMP_W'(-sample) : sve_pkg::SMP_W'(sample);
        sum_neg = sum_reg[sve_pkg::SUM_W-1];
        sum_abs = sum_neg ? (~sum_reg + sve_pkg::SUM_W'(1)) : sum_reg;
        sum_mag = sum_abs[sve_pkg::MUL_W-1:0];
        mean_up = div_rsp.quotient[sve_pkg::MEAN_W-1:0]
                  + {{(sve_pkg::MEAN_W-1){1'b0}}, div_rsp.rem_nz};

        state_next  = state_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        ssq_next    = ssq_reg;
        ovf_next    = ovf_reg;
        last_next   = last_reg;
        acc_en_next = acc_en_reg;
        op_a_next   = op_a_reg;
        op_b_next   = op_b_reg;
        acc_next    = acc_reg;
        den_next    = den_reg;
        done_next   = 1'b0;
        mean_next   = mean_reg;
        var_next    = var_reg;
        status_next = status_reg;

        div_req.go       = 1'b0;
        div_req.dividend = {acc_reg, {sve_pkg::FRAC_W{1'b0}}};
        div_req.divisor  = den_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    last_next = last_sample;
                    if (count_reg < sve_pkg::MAX_CNT)
                    begin
                        acc_en_next = 1'b1;
                        count_next  = count_reg + sve_pkg::CNT_W'(1);
                        sum_next    = sum_reg
                                      + {{(sve_pkg::SUM_W-sve_pkg::SMP_W){sample[sve_pkg::SMP_W-1]}},
                                         sample};
                        op_a_next   = {{(sve_pkg::MUL_W-sve_pkg::SMP_W){1'b0}}, smp_mag};
                        op_b_next   = {{(sve_pkg::MUL_W-sve_pkg::SMP_W){1'b0}}, smp_mag};
                    end
                    else
                    begin
                        // batch full: drop the sample, remember the overflow
                        acc_en_next = 1'b0;
                        ovf_next    = 1'b1;
                    end
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                state_next = ST_SQADD;
            end
            ST_SQADD:
            begin
                if (acc_en_reg)
                begin
                    ssq_next = ssq_reg + prod[sve_pkg::SSQ_W-1:0];
                end
                state_next = last_reg ? ST_CHK : ST_IDLE;
            end
            ST_CHK:
            begin
                if (ovf_reg || (count_reg < sve_pkg::MIN_CNT))
                begin
                    done_next   = 1'b1;
                    mean_next   = '0;
                    var_next    = '0;
                    status_next = ovf_reg ? sve_pkg::STATUS_OVER : sve_pkg::STATUS_SHORT;
                    count_next  = '0;
                    sum_next    = '0;
                    ssq_next    = '0;
                    ovf_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    op_a_next  = {{(sve_pkg::MUL_W-sve_pkg::CNT_W){1'b0}}, count_reg};
                    op_b_next  = ssq_reg[sve_pkg::MUL_W-1:0];
                    state_next = ST_P0;
                end
            end
            ST_P0:
            begin
                op_b_next  = {{(2*sve_pkg::MUL_W-sve_pkg::SSQ_W){1'b0}},
                              ssq_reg[sve_pkg::SSQ_W-1:sve_pkg::MUL_W]};
                state_next = ST_P1;
            end
            ST_P1:
            begin
                acc_next   = prod;
                op_a_next  = sum_mag;
                op_b_next  = sum_mag;
                state_next = ST_P2;
            end
            ST_P2:
            begin
                acc_next   = acc_reg + {prod[sve_pkg::MUL_W-1:0], {sve_pkg::MUL_W{1'b0}}};
                op_a_next  = {{(sve_pkg::MUL_W-sve_pkg::CNT_W){1'b0}}, count_reg};
                op_b_next  = {{(sve_pkg::MUL_W-sve_pkg::CNT_W){1'b0}},
                              count_reg - sve_pkg::CNT_W'(1)};
                state_next = ST_P3;
            end
            ST_P3:
            begin
                acc_next   = acc_reg - prod;
                state_next = ST_P4;
            end
            ST_P4:
            begin
                den_next   = prod[sve_pkg::DVS_W-1:0];
                state_next = ST_MSTART;
            end
            ST_MSTART:
            begin
                div_req.go       = 1'b1;
                div_req.dividend = {{(sve_pkg::DVD_W-sve_pkg::MUL_W-sve_pkg::FRAC_W){1'b0}},
                                    sum_mag, {sve_pkg::FRAC_W{1'b0}}};
                div_req.divisor  = {{(sve_pkg::DVS_W-sve_pkg::CNT_W){1'b0}}, count_reg};
                state_next       = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (div_rsp.done)
                begin
                    // floor of a negative quotient: negate magnitude rounded up
                    mean_next  = sum_neg ? (sve_pkg::MEAN_W'(0) - mean_up)
                                         : div_rsp.quotient[sve_pkg::MEAN_W-1:0];
                    state_next = ST_VSTART;
                end
            end
            ST_VSTART:
            begin
                div_req.go = 1'b1;
                state_next = ST_VWAIT;
            end
            ST_VWAIT:
            begin
                if (div_rsp.done)
                begin
                    done_next   = 1'b1;
                    var_next    = div_rsp.quotient;
                    status_next = sve_pkg::STATUS_OK;
                    count_next  = '0;
                    sum_next    = '0;
                    ssq_next    = '0;
                    ovf_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
            ssq_reg   <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ssq_reg   <= ssq_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        acc_en_reg <= acc_en_next;
        op_a_reg   <= op_a_next;
        op_b_reg   <= op_b_next;
        acc_reg    <= acc_next;
        den_reg    <= den_next;
        mean_reg   <= mean_next;
        var_reg    <= var_next;
        status_reg <= status_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign mean_q8     = mean_reg;
    assign variance_q8 = var_reg;
    assign status      = status_reg;

    `SVE_ASSERT_IMPL(a_done_idle, done, !busy)
    `SVE_ASSERT_IMPL(a_err_zero, done && (status != sve_pkg::STATUS_OK),
                     (mean_q8 == '0) && (variance_q8 == '0))
    `SVE_ASSERT_NEXT(a_accept_no_done, start && !busy, !done)
    `SVE_ASSERT_IMPL(a_div_wait, div_rsp.done, (state_reg == ST_MWAIT) || (state_reg == ST_VWAIT))

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for sample_variance_engine_core: drives sample requests,
// predicts each batch's floored Q8 mean and unbiased variance, checks each result.
// Depends on sve_pkg and the sample_variance_engine_core RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [sve_pkg::MEAN_W-1:0] mean;
        logic [sve_pkg::VAR_W-1:0]         variance;
        logic [sve_pkg::STATUS_W-1:0]      status;
    } batch_stats_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic signed [sve_pkg::SMP_W-1:0]   sample = '0;
    logic                               last_sample = 1'b0;
    logic                               busy;
    logic                               done;
    logic signed [sve_pkg::MEAN_W-1:0]  mean_q8;
    logic [sve_pkg::VAR_W-1:0]          variance_q8;
    logic [sve_pkg::STATUS_W-1:0]       status;

    // Predicted batch accumulators
    int                         batch_count = 0;
    longint                     batch_sum = 0;
    longint unsigned            batch_sumsq = 0;
    bit                         batch_over = 1'b0;

    batch_stats_t               expected_stats[$];
    int                         error_count = 0;
    bit                         idle_enable = 1'b1;

    sample_variance_engine_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .sample      (sample),
        .last_sample (last_sample),
        .busy        (busy),
        .done        (done),
        .mean_q8     (mean_q8),
        .variance_q8 (variance_q8),
        .status      (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Fold one accepted sample into the batch sums; on a marked sample queue the result.
    function automatic void update_batch_stats(input logic signed [sve_pkg::SMP_W-1:0] value,
                                               input logic mark);
        batch_stats_t    res;
        longint          n;
        longint          num;
        longint          q;
        longint unsigned nu;
        longint unsigned mag;
        longint unsigned d;
        longint unsigned den;
        longint unsigned vq;
        longint unsigned vr;
        if (batch_count < sve_pkg::MAX_SAMPLES)
        begin
            batch_count++;
            batch_sum += longint'(value);
            batch_sumsq += longint'(value) * longint'(value);
        end
        else
            batch_over = 1'b1;
        if (!mark)
            return;
        res.mean = '0;
        res.variance = '0;
        if (batch_over)
            res.status = sve_pkg::STATUS_OVER;
        else if (batch_count < 2)
            res.status = sve_pkg::STATUS_SHORT;
        else
        begin
            n = batch_count;
            num = batch_sum * 256;
            q = num / n;
            // round toward minus infinity
            if ((num % n) != 0 && num < 0)
                q--;
            res.mean = q[sve_pkg::MEAN_W-1:0];
            nu = n;
            mag = (batch_sum < 0) ? -batch_sum : batch_sum;
            d = nu * batch_sumsq - mag * mag;
            den = nu * (nu - 1);
            vq = d / den;
            vr = d % den;
            res.variance = sve_pkg::VAR_W'(vq * 256 + (vr * 256) / den);
            res.status = sve_pkg::STATUS_OK;
        end
        expected_stats.push_back(res);
        batch_count = 0;
        batch_sum = 0;
        batch_sumsq = 0;
        batch_over = 1'b0;
    endfunction

    // Call at a rising edge; returns at the edge that accepts the request, start left high.
    task automatic send_sample(input logic signed [sve_pkg::SMP_W-1:0] value, input logic mark);
        start <= 1'b1;
        sample <= value;
        last_sample <= mark;
        do
            @(posedge clk);
        while (busy);
        update_batch_stats(value, mark);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_pause();
        if (idle_enable && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 13));
    endtask

    // Hold off new requests until every queued result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [sve_pkg::SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return sve_pkg::SMP_W'(32767 - $urandom_range(0, 3));
            1: return sve_pkg::SMP_W'(-32768 + $urandom_range(0, 3));
            2: return sve_pkg::SMP_W'($urandom_range(0, 32) - 16);
            default: return sve_pkg::SMP_W'($urandom);
        endcase
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 1;
        else if (r < 85)
            return $urandom_range(2, 10);
        else if (r < 97)
            return $urandom_range(11, 60);
        else
            return $urandom_range(61, 200);
    endfunction

    task automatic send_random_batch(input int len);
        for (int i = 0; i < len; i++)
        begin
            maybe_pause();
            send_sample(pick_sample(), i == len - 1);
        end
    endtask

    task automatic test_extreme_values();
        send_sample(16'sh7fff, 1'b0);
        send_sample(-16'sh8000, 1'b1);
        repeat (3) send_sample(-16'sh8000, 1'b0);
        send_sample(-16'sh8000, 1'b1);
        repeat (3) send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0000, 1'b1);
    endtask

    task automatic test_short_batches();
        send_sample(-16'sh8000, 1'b1);
        maybe_pause();
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sh0000, 1'b1);
    endtask

    task automatic test_floor_rounding();
        // negative means and variances with a fractional remainder
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sd4, 1'b1);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(-16'sd2, 1'b1);
    endtask

    task automatic test_random_batches(input int items);
        int  sent;
        int  len;
        bit  drained;
        sent = 0;
        drained = 1'b0;
        while (sent < items)
        begin
            len = pick_length();
            send_random_batch(len);
            sent += len;
            if (!drained && sent >= items / 2)
            begin
                wait_for_results();
                @(posedge clk);
                drained = 1'b1;
            end
        end
    endtask

    task automatic test_streaming_tail(input int items);
        int sent;
        int len;
        sent = 0;
        idle_enable = 1'b0;
        while (sent < items)
        begin
            len = $urandom_range(1, 8);
            send_random_batch(len);
            sent += len;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        batch_stats_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_stats.size() == 0)
                report_mismatch("unexpected result", status, 0);
            else
            begin
                want = expected_stats.pop_front();
                if (mean_q8 !== want.mean)
                    report_mismatch("mean_q8", mean_q8, want.mean);
                if (variance_q8 !== want.variance)
                    report_mismatch("variance_q8", variance_q8, want.variance);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_values();
        test_short_batches();
        test_floor_rounding();
        test_random_batches(400);
        test_streaming_tail(60);
        wait_for_results();
        repeat (300) @(posedge clk);
        if (expected_stats.size() != 0)
            report_mismatch("results still pending", expected_stats.size(), 0);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
